>>> rtl/fcc_pkg.sv
// Shared types and constants of the flow classifier.
`default_nettype none
package fcc_pkg;
	localparam int FLOW_ENTRIES = 64;
	localparam int FLOW_IX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
	localparam int FLOW_CNT_W = $clog2(FLOW_ENTRIES + 1);

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

	typedef enum logic [1:0] {
		CLS_TCP   = 2'd0,
		CLS_UDP   = 2'd1,
		CLS_OTHER = 2'd2
	} pkt_class_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} fcc_state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic commit;
	} fcc_cmd_t;
endpackage
`default_nettype wire

>>> rtl/flow_classifier_with_counters.sv
// Top level of the flow classifier with per-protocol counters.
// One request per packet, in order: capture, a parallel compare of the 5-tuple
// against all stored flows, then commit of the insert and counters. A new
// request is taken only after the previous one has committed, and the commit
// waits while a previous result is still stalled. Flow table validity is a
// fill count, so no clearing pass follows reset. Counter outputs hold the totals
// after the packet shown.
`default_nettype none
module flow_classifier_with_counters (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ip_protocol,
	input  wire logic [31:0] src_addr,
	input  wire logic [31:0] dst_addr,
	input  wire logic [15:0] src_port,
	input  wire logic [15:0] dst_port,
	input  wire logic [15:0] ip_total_len,
	input  wire logic [3:0]  ip_hdr_words,
	input  wire logic [3:0]  tcp_data_offset,
	input  wire logic [15:0] udp_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       pkt_class,
	output logic [15:0]      payload_len,
	output logic             new_flow,
	output logic             table_full,
	output logic [31:0]      total_packets,
	output logic [31:0]      tcp_packets,
	output logic [31:0]      udp_packets,
	output logic [47:0]      tcp_bytes,
	output logic [47:0]      udp_bytes,
	output logic [6:0]       tcp_flows,
	output logic [6:0]       udp_flows
);
	import fcc_pkg::*;

	fcc_cmd_t cmd;

	fcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	fcc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.ip_protocol     (ip_protocol),
		.src_addr        (src_addr),
		.dst_addr        (dst_addr),
		.src_port        (src_port),
		.dst_port        (dst_port),
		.ip_total_len    (ip_total_len),
		.ip_hdr_words    (ip_hdr_words),
		.tcp_data_offset (tcp_data_offset),
		.udp_len         (udp_len),
		.pkt_class       (pkt_class),
		.payload_len     (payload_len),
		.new_flow        (new_flow),
		.table_full      (table_full),
		.total_packets   (total_packets),
		.tcp_packets     (tcp_packets),
		.udp_packets     (udp_packets),
		.tcp_bytes       (tcp_bytes),
		.udp_bytes       (udp_bytes),
		.tcp_flows       (tcp_flows),
		.udp_flows       (udp_flows)
	);
endmodule
`default_nettype wire

>>> rtl/fcc_ctrl.sv
// Controller: sequences capture, table compare and commit of each request.
`default_nettype none
module fcc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fcc_pkg::fcc_cmd_t      cmd
);
	import fcc_pkg::*;

	fcc_state_t state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_CMP;
			ST_CMP:  state_d = ST_UPD;
			ST_UPD:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.cmp    = (state_q == ST_CMP);
		cmd.commit = (state_q == ST_UPD) && out_free;
		in_stall   = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

	assign out_valid = out_valid_q;

	// a result is only replaced once the old one has gone
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !out_stall))
		else $error("commit over a pending result");
	a_load_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.cmp)
		else $error("compare did not follow capture");
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.cmp, cmd.commit}))
		else $error("overlapping commands");
endmodule
`default_nettype wire

>>> rtl/fcc_datapath.sv
// Datapath: flow table, payload length, saturating counters and result register.
`default_nettype none
module fcc_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  fcc_pkg::fcc_cmd_t      cmd,
	input  wire logic [7:0]        ip_protocol,
	input  wire logic [31:0]       src_addr,
	input  wire logic [31:0]       dst_addr,
	input  wire logic [15:0]       src_port,
	input  wire logic [15:0]       dst_port,
	input  wire logic [15:0]       ip_total_len,
	input  wire logic [3:0]        ip_hdr_words,
	input  wire logic [3:0]        tcp_data_offset,
	input  wire logic [15:0]       udp_len,
	output logic [1:0]             pkt_class,
	output logic [15:0]            payload_len,
	output logic                   new_flow,
	output logic                   table_full,
	output logic [31:0]            total_packets,
	output logic [31:0]            tcp_packets,
	output logic [31:0]            udp_packets,
	output logic [47:0]            tcp_bytes,
	output logic [47:0]            udp_bytes,
	output logic [6:0]             tcp_flows,
	output logic [6:0]             udp_flows
);
	import fcc_pkg::*;

	// captured request
	logic [7:0]  proto_q;
	logic [63:0] akey_q;
	logic [31:0] pkey_q;
	logic [15:0] tot_q, ulen_q;
	logic [3:0]  ihl_q, doff_q;

	// flow table; entries below fill_q are valid (inserts only, lowest free first)
	logic [63:0] flow_addr_pair [FLOW_ENTRIES];
	logic [31:0] flow_port_pair [FLOW_ENTRIES];
	logic        flow_is_udp    [FLOW_ENTRIES];
	logic [FLOW_CNT_W-1:0] fill_q;

	logic [FLOW_ENTRIES-1:0] match_s1;
	pkt_class_t cls_s1;
	logic [15:0] pay_s1;

	logic [31:0] tot_cnt_q, tcp_cnt_q, udp_cnt_q;
	logic [47:0] tcp_sum_q, udp_sum_q;
	logic [6:0]  tcp_fl_q, udp_fl_q;

	pkt_class_t cls_d;
	logic [15:0] pay_d;
	logic [6:0]  hdr_bytes;
	logic        is_udp;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			proto_q <= ip_protocol;
			akey_q  <= {src_addr, dst_addr};
			pkey_q  <= {src_port, dst_port};
			tot_q   <= ip_total_len;
			ulen_q  <= udp_len;
			ihl_q   <= ip_hdr_words;
			doff_q  <= tcp_data_offset;
		end
	end

	assign is_udp = (proto_q == PROTO_UDP);
	assign hdr_bytes = {5'({1'b0, ihl_q} + {1'b0, doff_q}), 2'b00};

	always_comb begin
		cls_d = CLS_OTHER;
		pay_d = '0;
		if (proto_q == PROTO_TCP) begin
			cls_d = CLS_TCP;
			pay_d = (tot_q > 16'(hdr_bytes)) ? tot_q - 16'(hdr_bytes) : '0;
		end else if (is_udp) begin
			cls_d = CLS_UDP;
			pay_d = (ulen_q > UDP_HDR_BYTES) ? ulen_q - UDP_HDR_BYTES : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			cls_s1 <= cls_d;
			pay_s1 <= pay_d;
			for (int i = 0; i < FLOW_ENTRIES; i++) begin
				match_s1[i] <= (FLOW_CNT_W'(i) < fill_q) && (flow_addr_pair[i] == akey_q)
					&& (flow_port_pair[i] == pkey_q) && (flow_is_udp[i] == is_udp);
			end
		end
	end

	logic is_flow, found, do_insert, no_room;
	logic [48:0] tcp_sum_n, udp_sum_n;

	assign is_flow   = (cls_s1 != CLS_OTHER);
	assign found     = |match_s1;
	assign no_room   = (fill_q == FLOW_CNT_W'(FLOW_ENTRIES));
	assign do_insert = is_flow && !found && !no_room;
	assign tcp_sum_n = {1'b0, tcp_sum_q} + 49'(pay_s1);
	assign udp_sum_n = {1'b0, udp_sum_q} + 49'(pay_s1);

	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			flow_addr_pair[fill_q[FLOW_IX_W-1:0]] <= akey_q;
			flow_port_pair[fill_q[FLOW_IX_W-1:0]] <= pkey_q;
			flow_is_udp[fill_q[FLOW_IX_W-1:0]]    <= (cls_s1 == CLS_UDP);
		end
		if (cmd.commit) begin
			pkt_class   <= cls_s1;
			payload_len <= pay_s1;
			new_flow    <= do_insert;
			table_full  <= is_flow && !found && no_room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			tot_cnt_q <= '0;
			tcp_cnt_q <= '0;
			udp_cnt_q <= '0;
			tcp_sum_q <= '0;
			udp_sum_q <= '0;
			tcp_fl_q  <= '0;
			udp_fl_q  <= '0;
		end else if (cmd.commit) begin
			if (!(&tot_cnt_q)) tot_cnt_q <= tot_cnt_q + 32'd1;
			if (do_insert) fill_q <= fill_q + FLOW_CNT_W'(1);
			if (cls_s1 == CLS_TCP) begin
				if (!(&tcp_cnt_q)) tcp_cnt_q <= tcp_cnt_q + 32'd1;
				tcp_sum_q <= tcp_sum_n[48] ? '1 : tcp_sum_n[47:0];
				if (do_insert && !(&tcp_fl_q)) tcp_fl_q <= tcp_fl_q + 7'd1;
			end else if (cls_s1 == CLS_UDP) begin
				if (!(&udp_cnt_q)) udp_cnt_q <= udp_cnt_q + 32'd1;
				udp_sum_q <= udp_sum_n[48] ? '1 : udp_sum_n[47:0];
				if (do_insert && !(&udp_fl_q)) udp_fl_q <= udp_fl_q + 7'd1;
			end
		end
	end

	assign total_packets = tot_cnt_q;
	assign tcp_packets   = tcp_cnt_q;
	assign udp_packets   = udp_cnt_q;
	assign tcp_bytes     = tcp_sum_q;
	assign udp_bytes     = udp_sum_q;
	assign tcp_flows     = tcp_fl_q;
	assign udp_flows     = udp_fl_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FLOW_CNT_W'(FLOW_ENTRIES))
		else $error("flow table fill beyond depth");
	a_hit_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && found) |=> $stable(fill_q))
		else $error("table grew on a hit");
	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.commit) |-> !(new_flow && table_full))
		else $error("new flow and table full together");
endmodule
`default_nettype wire
